// ===== design/rei_pkg.sv =====
// ----------------------------------------------------------------------------
// rei_pkg
// Shared types, constants and the quadrature step table for the rotary
// encoder interface.
// ----------------------------------------------------------------------------
package rei_pkg;

    // Accumulator width default (signed sub-step total)
    localparam int ACC_BITS_DEF = 16;

    // Stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int DET_W       = 16;
    localparam int DET_MAX     = 32767;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_DETENT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_DIRECTION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS       = 2'd2;

    localparam logic [3:0] STEPS_RESET    = 4'd4;
    localparam logic       REVERSE_RESET  = 1'b0;
    localparam logic [7:0] DEBOUNCE_RESET = 8'd20;

    localparam logic [1:0] PHASES_RESET = 2'b11;
    localparam logic [7:0] MS_SAT       = 8'hFF;

    // Quotient bits resolved per divider cycle
    localparam int DIGIT_BITS = 4;

    // Depth of the queue between front and back
    localparam int Q_DEPTH = 2;

    // Gray-code step, indexed by {previous A,B, current A,B}
    localparam logic signed [1:0] GRAY_STEP [16] = '{
         2'sd0, -2'sd1,  2'sd1,  2'sd0,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd0,  2'sd1, -2'sd1,  2'sd0
    };

    typedef struct packed {
        logic [1:0] phases;      // {A, B}
        logic       pressed;
        logic       tick;
        logic       take_delta;
        logic       take_click;
    } item_t;

    typedef struct packed {
        logic [3:0] steps_per_detent;
        logic       reverse_direction;
        logic [7:0] debounce_ms;
    } cfg_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_FIX
    } back_state_t;

endpackage

// ===== design/rei_queue.sv =====
// ----------------------------------------------------------------------------
// rei_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module rei_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  rei_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output rei_pkg::item_t  pop_item
);

    localparam int PTR_W = (rei_pkg::Q_DEPTH > 1) ? $clog2(rei_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(rei_pkg::Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(rei_pkg::Q_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(rei_pkg::Q_DEPTH);

    rei_pkg::item_t   entry_reg [rei_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/rei_front.sv =====
// ----------------------------------------------------------------------------
// rei_front
// Accepts input transactions and configuration writes, decodes the packed
// sample into an item and pushes it onto the queue.
// ----------------------------------------------------------------------------
module rei_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rei_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rei_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rei_pkg::CFG_DATA_W-1:0]   cfg_data,
    output rei_pkg::cfg_t                    cfg,
    input  logic                             q_full,
    output logic                             q_push,
    output rei_pkg::item_t                   q_item
);

    logic [3:0] steps_reg, steps_next;
    logic       reverse_reg, reverse_next;
    logic [7:0] debounce_reg, debounce_next;

    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;
    assign q_push    = s_tvalid && !q_full;

    // Pins arrive raw; switch is active low
    assign q_item.phases     = {s_tdata[0], s_tdata[1]};
    assign q_item.pressed    = !s_tdata[2];
    assign q_item.tick       = s_tdata[3];
    assign q_item.take_delta = s_tdata[4];
    assign q_item.take_click = s_tdata[5];

    assign cfg.steps_per_detent  = steps_reg;
    assign cfg.reverse_direction = reverse_reg;
    assign cfg.debounce_ms       = debounce_reg;

    always_comb begin
        steps_next    = steps_reg;
        reverse_next  = reverse_reg;
        debounce_next = debounce_reg;
        if (cfg_valid) begin
            case (cfg_index)
                rei_pkg::CFG_STEPS_PER_DETENT:  steps_next    = cfg_data[3:0];
                rei_pkg::CFG_REVERSE_DIRECTION: reverse_next  = cfg_data[0];
                rei_pkg::CFG_DEBOUNCE_MS:       debounce_next = cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg    <= rei_pkg::STEPS_RESET;
            reverse_reg  <= rei_pkg::REVERSE_RESET;
            debounce_reg <= rei_pkg::DEBOUNCE_RESET;
        end else begin
            steps_reg    <= steps_next;
            reverse_reg  <= reverse_next;
            debounce_reg <= debounce_next;
        end
    end

endmodule

// ===== design/rei_back.sv =====
// ----------------------------------------------------------------------------
// rei_back
// Executes queued items: quadrature accumulate, switch debounce, click latch,
// and the detent read through a 4-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
module rei_back #(
    parameter int ACC_BITS = rei_pkg::ACC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  rei_pkg::cfg_t                    cfg,
    input  logic                             q_valid,
    input  rei_pkg::item_t                   q_item,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rei_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    localparam int DB        = rei_pkg::DIGIT_BITS;
    localparam int MW        = ACC_BITS - 1;
    localparam int DIV_STEPS = (MW + DB - 1) / DB;
    localparam int PW        = DIV_STEPS * DB;
    localparam int CNT_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int CW        = (PW > rei_pkg::DET_W) ? PW : rei_pkg::DET_W;
    localparam int PROD_W    = 19;
    localparam int NW        = (PW > PROD_W) ? PW : PROD_W;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);
    localparam logic signed [ACC_BITS:0] LIM  = {2'b00, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS:0] NLIM = -LIM;

    rei_pkg::back_state_t state_reg, state_next;

    logic signed [ACC_BITS-1:0] total_reg, total_next;
    logic [1:0]                 phases_reg, phases_next;
    logic                       pressed_reg, pressed_next;
    logic [7:0]                 ms_reg, ms_next;
    logic                       latch_reg, latch_next;

    logic                       neg_reg, neg_next;
    logic [PW-1:0]              mag_reg, mag_next;
    logic [PW-1:0]              dvd_reg, dvd_next;
    logic [DB-1:0]              rem_reg, rem_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;

    logic                       m_valid_reg, m_valid_next;
    logic [rei_pkg::DET_W-1:0]  m_det_reg, m_det_next;
    logic                       m_clicked_reg, m_clicked_next;

    logic [3:0]                 spd;
    logic                       out_free;

    // Encoder and switch update of the item at the head of the queue
    logic signed [1:0]          step;
    logic signed [ACC_BITS:0]   sum;
    logic signed [ACC_BITS-1:0] sat_total;
    logic [ACC_BITS-1:0]        sat_mag;
    logic [7:0]                 ms_tick;
    logic                       edge_ok;
    logic                       latch_after;

    // Divider step
    logic [DB-1:0]              st_rem;
    logic [PW-1:0]              st_dvd;
    logic [DB:0]                trial;

    // Final fix-up
    logic [CW-1:0]              quo_w;
    logic                       quo_over;
    logic [14:0]                quo_c;
    logic [PROD_W-1:0]          prod;
    logic [NW-1:0]              new_mag;
    logic [ACC_BITS-1:0]        new_mag_acc;
    logic signed [ACC_BITS-1:0] fix_total;
    logic [rei_pkg::DET_W-1:0]  det_pos;
    logic [rei_pkg::DET_W-1:0]  det_out;

    assign spd      = (cfg.steps_per_detent == 4'd0) ? 4'd1 : cfg.steps_per_detent;
    assign out_free = !m_valid_reg || m_tready;

    assign step      = rei_pkg::GRAY_STEP[{phases_reg, q_item.phases}];
    assign sum       = {total_reg[ACC_BITS-1], total_reg} + (ACC_BITS+1)'(step);
    assign sat_total = (sum > LIM)  ? ACC_BITS'(LIM)  :
                       (sum < NLIM) ? ACC_BITS'(NLIM) : sum[ACC_BITS-1:0];
    assign sat_mag   = sat_total[ACC_BITS-1] ? ACC_BITS'(-sat_total)
                                             : ACC_BITS'(sat_total);

    assign ms_tick   = (q_item.tick && ms_reg != rei_pkg::MS_SAT) ? ms_reg + 8'd1 : ms_reg;
    assign edge_ok   = (q_item.pressed != pressed_reg) && (ms_tick >= cfg.debounce_ms);
    assign latch_after = latch_reg || (edge_ok && q_item.pressed);

    // Four restoring steps per cycle; quotient bits shift in at the bottom
    always_comb begin
        st_rem = rem_reg;
        st_dvd = dvd_reg;
        trial  = '0;
        for (int i = 0; i < DB; i++) begin
            trial = {st_rem, st_dvd[PW-1]};
            if (trial >= {1'b0, spd}) begin
                st_rem = DB'(trial - {1'b0, spd});
                st_dvd = {st_dvd[PW-2:0], 1'b1};
            end else begin
                st_rem = trial[DB-1:0];
                st_dvd = {st_dvd[PW-2:0], 1'b0};
            end
        end
    end

    assign quo_w       = CW'(dvd_reg);
    assign quo_over    = quo_w > CW'(rei_pkg::DET_MAX);
    assign quo_c       = quo_over ? 15'(rei_pkg::DET_MAX) : quo_w[14:0];
    assign prod        = PROD_W'(quo_c) * PROD_W'(spd);
    assign new_mag     = NW'(mag_reg) - NW'(prod);
    assign new_mag_acc = ACC_BITS'(new_mag[MW-1:0]);
    assign fix_total   = neg_reg ? -$signed(new_mag_acc) : $signed(new_mag_acc);
    assign det_pos     = {1'b0, quo_c};
    assign det_out     = (neg_reg ^ cfg.reverse_direction) ? -det_pos : det_pos;

    always_comb begin
        state_next     = state_reg;
        total_next     = total_reg;
        phases_next    = phases_reg;
        pressed_next   = pressed_reg;
        ms_next        = ms_reg;
        latch_next     = latch_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_det_next     = m_det_reg;
        m_clicked_next = m_clicked_reg;
        q_pop          = 1'b0;
        case (state_reg)
            rei_pkg::BK_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop       = 1'b1;
                    total_next  = sat_total;
                    phases_next = q_item.phases;
                    ms_next     = edge_ok ? 8'd0 : ms_tick;
                    if (edge_ok) begin
                        pressed_next = q_item.pressed;
                    end
                    if (q_item.take_click) begin
                        m_clicked_next = latch_after;
                        latch_next     = 1'b0;
                    end else begin
                        m_clicked_next = 1'b0;
                        latch_next     = latch_after;
                    end
                    if (q_item.take_delta) begin
                        neg_next   = sat_total[ACC_BITS-1];
                        mag_next   = PW'(sat_mag);
                        dvd_next   = PW'(sat_mag);
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = rei_pkg::BK_DIV;
                    end else begin
                        m_det_next   = '0;
                        m_valid_next = 1'b1;
                    end
                end
            end
            rei_pkg::BK_DIV: begin
                dvd_next = st_dvd;
                rem_next = st_rem;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = rei_pkg::BK_FIX;
                end
            end
            rei_pkg::BK_FIX: begin
                total_next   = fix_total;
                m_det_next   = det_out;
                m_valid_next = 1'b1;
                state_next   = rei_pkg::BK_IDLE;
            end
            default: begin
                state_next = rei_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rei_pkg::BK_IDLE;
            total_reg   <= '0;
            phases_reg  <= rei_pkg::PHASES_RESET;
            pressed_reg <= 1'b0;
            ms_reg      <= '0;
            latch_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            phases_reg  <= phases_next;
            pressed_reg <= pressed_next;
            ms_reg      <= ms_next;
            latch_reg   <= latch_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg       <= neg_next;
        mag_reg       <= mag_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        m_det_reg     <= m_det_next;
        m_clicked_reg <= m_clicked_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(rei_pkg::OUT_TDATA_W - rei_pkg::DET_W - 1){1'b0}},
                       m_clicked_reg, m_det_reg};

    // Output slot stays empty while a delta read is in the divider
    a_out_empty_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != rei_pkg::BK_IDLE) |-> !m_valid_reg)
        else $error("result pending while divider busy");

    // Accumulator never reaches the most negative code
    a_total_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg != {1'b1, {(ACC_BITS-1){1'b0}}})
        else $error("sub-step total outside saturation range");

    // Partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rei_pkg::BK_DIV) |-> (rem_reg < spd))
        else $error("divider remainder not below divisor");

    // An accepted switch edge restarts the millisecond count
    a_edge_clears_ms: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(pressed_reg) |-> (ms_reg == 8'd0))
        else $error("switch edge without tick count restart");

    // Click latches only on an accepted press
    a_click_on_press: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(latch_reg) |-> $rose(pressed_reg))
        else $error("click latched without accepted press");

endmodule

// ===== design/rotary_encoder_interface.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_interface
// Quadrature encoder decoder with debounced push switch and detent readout.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transaction per pin sample, carrying phase levels, the
//   switch pin, a millisecond tick and the take-delta / take-click requests.
//   m_ channel: exactly one result transaction per sample, in order, with the
//   detents taken (zero unless requested) and the consumed click flag.
//   cfg_ channel: register writes, always ready; write only while idle.
// Flow: a sample without a delta read is popped in the idle state and its
//   result registered for m_tvalid; such samples stream at one per cycle
//   while m_tready holds. A delta read then runs the restoring divider, four
//   quotient bits a cycle, then a fix-up state; no sample is popped meanwhile.
// A two-entry queue decouples input acceptance from execution, so samples
//   are still taken while a result waits or the divider runs.
// Reset: aresetn low for one edge returns registers, accumulator, phase
//   history, switch state and click latch to their defaults; queue and
//   output slot are emptied.
// Receiver stall: the result holds on m_tdata; the back end halts, the
//   queue fills and s_tready drops once it is full.
// ----------------------------------------------------------------------------
module rotary_encoder_interface #(
    parameter int ACC_BITS = rei_pkg::ACC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [0] phase_a, [1] phase_b, [2] switch_level, [3] ms_tick,
    // [4] take_delta, [5] take_click, [7:6] zero
    input  logic [rei_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [15:0] detents (signed), [16] clicked, [23:17] zero
    output logic [rei_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rei_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rei_pkg::CFG_DATA_W-1:0]   cfg_data
);

    rei_pkg::cfg_t  cfg;
    rei_pkg::item_t push_item;
    rei_pkg::item_t pop_item;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_not_empty;

    rei_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    rei_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (pop_item)
    );

    rei_back #(
        .ACC_BITS (ACC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_not_empty),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
